/* hw/rtl/source_text_tokenizer_macros.svh */
// Assertion macros used by the tokenizer RTL.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/stt_pkg.sv */
package stt_pkg;

  localparam int LineBitsDefault = 32;
  localparam int QueueDepth = 4;
  localparam int KwCount = 9;

  typedef enum logic [5:0] {
    KIND_SEMI, KIND_COMMA, KIND_DOT, KIND_COLON, KIND_LPAREN, KIND_RPAREN,
    KIND_LBRACK, KIND_RBRACK, KIND_LBRACE, KIND_RBRACE, KIND_ASSIGN, KIND_EQ,
    KIND_AND, KIND_LAND, KIND_OR, KIND_LOR, KIND_XOR, KIND_NOT, KIND_NE,
    KIND_ADD, KIND_ADD_ASSIGN, KIND_SUB, KIND_SUB_ASSIGN, KIND_MUL,
    KIND_MUL_ASSIGN, KIND_DIV, KIND_DIV_ASSIGN, KIND_LT, KIND_LE, KIND_GT,
    KIND_GE, KIND_STRING, KIND_IDENT, KIND_KW_TYPE, KIND_KW_IF, KIND_KW_IFN,
    KIND_KW_INT8, KIND_KW_ELSE, KIND_KW_FOR, KIND_KW_WHILE, KIND_KW_RETURN,
    KIND_KW_NAMESPACE, KIND_NUMBER, KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    WARN_NONE, WARN_ESCAPE, WARN_DOT, WARN_OPEN
  } warn_t;

  typedef enum logic [8:0] {
    MODE_IDLE  = 9'b000000001,
    MODE_OP    = 9'b000000010,
    MODE_LINE  = 9'b000000100,
    MODE_BLOCK = 9'b000001000,
    MODE_STAR  = 9'b000010000,
    MODE_STR   = 9'b000100000,
    MODE_ESC   = 9'b001000000,
    MODE_IDENT = 9'b010000000,
    MODE_NUM   = 9'b100000000
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    logic        pay;
    logic [7:0]  data;
    logic [31:0] line;
    warn_t       warn;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    kind_t      single;
    kind_t      joined;
    logic [7:0] follow;
    logic       has_follow;
  } op_t;

  // Keyword text is right-justified: character i of a keyword of length L
  // sits at bits [8*(L-1-i) +: 8].
  localparam logic [71:0] KW_TEXT [KwCount] = '{
    "type", "if", "ifn", "int8", "else", "for", "while", "return", "namespace"
  };
  localparam logic [3:0] KW_LEN [KwCount] = '{
    4'd4, 4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd5, 4'd6, 4'd9
  };

  function automatic logic [KwCount-1:0] kw_feed(logic [KwCount-1:0] cand,
                                                 logic [3:0] len, logic [7:0] b);
    logic [KwCount-1:0] res;
    int pos;
    res = cand;
    for (int k = 0; k < KwCount; k++) begin
      if (len < KW_LEN[k]) begin
        pos = 8 * (int'(KW_LEN[k]) - 1 - int'(len));
        if (KW_TEXT[k][pos +: 8] != b) begin
          res[k] = 1'b0;
        end
      end else begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic kind_t kw_kind(logic [KwCount-1:0] cand, logic [3:0] len);
    kind_t kind;
    kind = KIND_IDENT;
    for (int k = KwCount - 1; k >= 0; k--) begin
      if (cand[k] && len == KW_LEN[k]) begin
        kind = kind_t'(6'(int'(KIND_KW_TYPE) + k));
      end
    end
    return kind;
  endfunction

  function automatic op_t op_info(logic [7:0] op);
    op_t oc;
    oc.follow = "=";
    oc.has_follow = 1'b1;
    case (op)
      "=": begin oc.single = KIND_ASSIGN; oc.joined = KIND_EQ; end
      "&": begin oc.single = KIND_AND; oc.joined = KIND_LAND; oc.follow = "&"; end
      "|": begin oc.single = KIND_OR; oc.joined = KIND_LOR; oc.follow = "|"; end
      "!": begin oc.single = KIND_NOT; oc.joined = KIND_NE; end
      "+": begin oc.single = KIND_ADD; oc.joined = KIND_ADD_ASSIGN; end
      "-": begin oc.single = KIND_SUB; oc.joined = KIND_SUB_ASSIGN; end
      "*": begin oc.single = KIND_MUL; oc.joined = KIND_MUL_ASSIGN; end
      "/": begin oc.single = KIND_DIV; oc.joined = KIND_DIV_ASSIGN; end
      "<": begin oc.single = KIND_LT; oc.joined = KIND_LE; end
      ">": begin oc.single = KIND_GT; oc.joined = KIND_GE; end
      default: begin
        oc.single = KIND_ERROR;
        oc.joined = KIND_ERROR;
        oc.has_follow = 1'b0;
      end
    endcase
    return oc;
  endfunction

  // Returns {valid escape, decoded byte}.
  function automatic logic [8:0] decode_escape(logic [7:0] b);
    logic [8:0] res;
    case (b)
      "n":  res = {1'b1, 8'h0A};
      "t":  res = {1'b1, 8'h09};
      "\"": res = {1'b1, 8'h22};
      "\\": res = {1'b1, 8'h5C};
      "v":  res = {1'b1, 8'h0B};
      "r":  res = {1'b1, 8'h0D};
      "f":  res = {1'b1, 8'h0C};
      "0":  res = {1'b1, 8'h00};
      default: res = {1'b0, b};
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/stt_lexer.sv */
module stt_lexer import stt_pkg::*; #(
  parameter int LINE_BITS = LineBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] text_byte,
  output push_t      push
);

  localparam int ExtW = (LINE_BITS > 32) ? LINE_BITS : 32;

  mode_t                 mode, mode_next;
  logic [7:0]            pend, pend_next;
  logic [KwCount-1:0]    cand, cand_next;
  logic [3:0]            idlen, idlen_next;
  logic                  dot, dot_next;
  logic [LINE_BITS-1:0]  line_cnt, line_cnt_next;

  logic [LINE_BITS-1:0]  line_inc;
  logic [ExtW-1:0]       line_ext;
  logic [7:0]            b;
  logic [3:0]            idlen_inc;
  op_t                   oc;
  logic [8:0]            esc;

  logic                  idle_emit, idle_clear, idle_op, idle_id, idle_num;
  kind_t                 idle_kind;
  logic                  idle_pay;
  logic [7:0]            idle_data;
  mode_t                 idle_mode;
  logic [LINE_BITS-1:0]  idle_line;

  logic                  chain, pre_emit;
  res_t                  pre, idle_res;

  assign b = text_byte;
  assign line_inc = (line_cnt != '1) ? LINE_BITS'(line_cnt + 1'b1) : line_cnt;
  assign line_ext = ExtW'(line_cnt);
  assign idlen_inc = (idlen != 4'hF) ? 4'(idlen + 1'b1) : idlen;
  assign oc = op_info(pend);
  assign esc = decode_escape(b);

  always_comb begin
    idle_emit = 1'b0;
    idle_clear = 1'b0;
    idle_op = 1'b0;
    idle_id = 1'b0;
    idle_num = 1'b0;
    idle_kind = KIND_ERROR;
    idle_pay = 1'b0;
    idle_data = 8'h00;
    idle_mode = MODE_IDLE;
    idle_line = line_cnt;
    case (b)
      8'h00: begin
        idle_clear = 1'b1;
        idle_line = '0;
      end
      8'h0A: idle_line = line_inc;
      8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: ;
      ";": begin idle_emit = 1'b1; idle_kind = KIND_SEMI; end
      ",": begin idle_emit = 1'b1; idle_kind = KIND_COMMA; end
      ".": begin idle_emit = 1'b1; idle_kind = KIND_DOT; end
      ":": begin idle_emit = 1'b1; idle_kind = KIND_COLON; end
      "(": begin idle_emit = 1'b1; idle_kind = KIND_LPAREN; end
      ")": begin idle_emit = 1'b1; idle_kind = KIND_RPAREN; end
      "[": begin idle_emit = 1'b1; idle_kind = KIND_LBRACK; end
      "]": begin idle_emit = 1'b1; idle_kind = KIND_RBRACK; end
      "{": begin idle_emit = 1'b1; idle_kind = KIND_LBRACE; end
      "}": begin idle_emit = 1'b1; idle_kind = KIND_RBRACE; end
      "^": begin idle_emit = 1'b1; idle_kind = KIND_XOR; end
      "=", "&", "|", "!", "+", "-", "*", "/", "<", ">": begin
        idle_mode = MODE_OP;
        idle_op = 1'b1;
      end
      "\"": idle_mode = MODE_STR;
      default: begin
        idle_emit = 1'b1;
        if (b inside {["a":"z"], ["A":"Z"], "_"}) begin
          idle_mode = MODE_IDENT;
          idle_id = 1'b1;
          idle_kind = KIND_IDENT;
          idle_pay = 1'b1;
          idle_data = b;
        end else if (b inside {["0":"9"]}) begin
          idle_mode = MODE_NUM;
          idle_num = 1'b1;
          idle_kind = KIND_NUMBER;
          idle_pay = 1'b1;
          idle_data = b;
        end else begin
          idle_data = b;
        end
      end
    endcase
  end

  always_comb begin
    mode_next = mode;
    pend_next = pend;
    cand_next = cand;
    idlen_next = idlen;
    dot_next = dot;
    line_cnt_next = line_cnt;
    chain = 1'b0;
    pre_emit = 1'b0;
    pre.kind = KIND_ERROR;
    pre.pay = 1'b0;
    pre.data = 8'h00;
    pre.line = line_ext[31:0];
    pre.warn = WARN_NONE;
    pre.last = 1'b0;

    case (mode)
      MODE_OP: begin
        mode_next = MODE_IDLE;
        pend_next = 8'h00;
        if (oc.single == KIND_DIV && b == "/") begin
          mode_next = MODE_LINE;
        end else if (oc.single == KIND_DIV && b == "*") begin
          mode_next = MODE_BLOCK;
        end else if (oc.has_follow && b == oc.follow) begin
          pre_emit = 1'b1;
          pre.kind = oc.joined;
        end else begin
          pre_emit = 1'b1;
          pre.kind = oc.single;
          chain = 1'b1;
        end
      end
      MODE_LINE: begin
        if (b == 8'h0A) begin
          line_cnt_next = line_inc;
          mode_next = MODE_IDLE;
        end else if (b == 8'h00) begin
          chain = 1'b1;
        end
      end
      MODE_BLOCK, MODE_STAR: begin
        if (b == 8'h00) begin
          pre_emit = 1'b1;
          pre.kind = KIND_ERROR;
          pre.warn = WARN_OPEN;
          chain = 1'b1;
        end else if (mode == MODE_STAR && b == "/") begin
          mode_next = MODE_IDLE;
        end else begin
          if (b == 8'h0A) begin
            line_cnt_next = line_inc;
          end
          mode_next = (b == "*") ? MODE_STAR : MODE_BLOCK;
        end
      end
      MODE_STR, MODE_ESC: begin
        pre_emit = 1'b1;
        pre.kind = KIND_STRING;
        if (b == 8'h00) begin
          pre.warn = WARN_OPEN;
          chain = 1'b1;
        end else if (mode == MODE_ESC) begin
          if (b == 8'h0A) begin
            line_cnt_next = line_inc;
          end
          pre.pay = 1'b1;
          pre.data = esc[7:0];
          pre.warn = esc[8] ? WARN_NONE : WARN_ESCAPE;
          mode_next = MODE_STR;
        end else if (b == "\"") begin
          mode_next = MODE_IDLE;
        end else if (b == "\\") begin
          pre_emit = 1'b0;
          mode_next = MODE_ESC;
        end else begin
          if (b == 8'h0A) begin
            line_cnt_next = line_inc;
          end
          pre.pay = 1'b1;
          pre.data = b;
        end
      end
      MODE_IDENT: begin
        pre_emit = 1'b1;
        if (b inside {["a":"z"], ["A":"Z"], "_", ["0":"9"]}) begin
          cand_next = kw_feed(cand, idlen, b);
          idlen_next = idlen_inc;
          pre.kind = KIND_IDENT;
          pre.pay = 1'b1;
          pre.data = b;
        end else begin
          pre.kind = kw_kind(cand, idlen);
          cand_next = '0;
          idlen_next = 4'h0;
          chain = 1'b1;
        end
      end
      MODE_NUM: begin
        pre_emit = 1'b1;
        pre.kind = KIND_NUMBER;
        if (b inside {["0":"9"]}) begin
          pre.pay = 1'b1;
          pre.data = b;
        end else if (b == ".") begin
          pre.pay = 1'b1;
          pre.data = b;
          pre.warn = dot ? WARN_DOT : WARN_NONE;
          dot_next = 1'b1;
        end else begin
          dot_next = 1'b0;
          chain = 1'b1;
        end
      end
      default: chain = 1'b1;
    endcase

    if (chain) begin
      mode_next = idle_mode;
      line_cnt_next = idle_line;
      if (idle_clear) begin
        pend_next = 8'h00;
        cand_next = '0;
        idlen_next = 4'h0;
        dot_next = 1'b0;
      end
      if (idle_op) begin
        pend_next = b;
      end
      if (idle_id) begin
        cand_next = kw_feed('1, 4'h0, b);
        idlen_next = 4'h1;
      end
      if (idle_num) begin
        dot_next = 1'b0;
      end
    end
  end

  always_comb begin
    idle_res.kind = idle_kind;
    idle_res.pay = idle_pay;
    idle_res.data = idle_data;
    idle_res.line = line_ext[31:0];
    idle_res.warn = WARN_NONE;
    idle_res.last = 1'b1;
    push.cnt = 2'd0;
    push.r0 = pre;
    push.r1 = idle_res;
    if (fire) begin
      if (pre_emit && chain && idle_emit) begin
        push.cnt = 2'd2;
      end else if (pre_emit) begin
        push.cnt = 2'd1;
        push.r0.last = 1'b1;
      end else if (chain && idle_emit) begin
        push.cnt = 2'd1;
        push.r0 = idle_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      pend <= 8'h00;
      cand <= '0;
      idlen <= 4'h0;
      dot <= 1'b0;
      line_cnt <= '0;
    end else if (fire) begin
      mode <= mode_next;
      pend <= pend_next;
      cand <= cand_next;
      idlen <= idlen_next;
      dot <= dot_next;
      line_cnt <= line_cnt_next;
    end
  end

endmodule

/* hw/rtl/stt_queue.sv */
module stt_queue import stt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  input  logic  pop,
  output res_t  head,
  output logic  valid,
  output logic  space
);

  localparam int AddrW = $clog2(QueueDepth);

  res_t             mem [QueueDepth];
  logic [AddrW-1:0] wp, rp;
  logic [AddrW:0]   cnt;

  assign valid = (cnt != '0);
  assign space = (cnt <= (AddrW + 1)'(QueueDepth - 2));
  assign head = mem[rp];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wp] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[AddrW'(wp + 1'b1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      wp <= AddrW'(wp + push.cnt);
      if (pop) begin
        rp <= AddrW'(rp + 1'b1);
      end
      cnt <= (AddrW + 1)'(cnt + push.cnt - {{AddrW{1'b0}}, pop});
    end
  end

endmodule

/* hw/rtl/source_text_tokenizer.sv */
// Streaming tokenizer: one source byte per beat in, token results out. Bytes
// are taken at one per cycle while the result queue has space; every byte
// passes an input register, combinational lexing logic, and a four-entry
// result queue. A byte yields up to two results and the queue drains one
// result per cycle while m_tready is high, so the sustained rate is one byte
// per cycle while each byte yields at most one result, and one result beat
// per cycle otherwise. A zero byte ends the text, flushes any open token and
// returns the line count to zero.
`include "source_text_tokenizer_macros.svh"

module source_text_tokenizer import stt_pkg::*; #(
  parameter int LINE_BITS = LineBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // payload_byte, line_number, warning, zero fill
  output logic [6:0]  m_tuser,   // token_kind, is_payload
  output logic        m_tlast    // last_of_run
);

  logic       byte_vld;
  logic [7:0] byte_q;
  logic       fire;
  logic       space;
  push_t      push;
  res_t       head;

  assign fire = byte_vld && space;
  assign s_tready = !byte_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (s_tready) begin
      byte_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      byte_q <= s_tdata;
    end
  end

  stt_lexer #(
    .LINE_BITS(LINE_BITS)
  ) u_lexer (
    .clk(clk),
    .rst(rst),
    .fire(fire),
    .text_byte(byte_q),
    .push(push)
  );

  stt_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .pop(m_tvalid && m_tready),
    .head(head),
    .valid(m_tvalid),
    .space(space)
  );

  assign m_tdata = {6'b000000, head.warn, head.line, head.data};
  assign m_tuser = {head.pay, head.kind};
  assign m_tlast = head.last;

  `STT_ASSERT_IMPLY(a_payload_kind, clk, rst, m_tvalid && head.pay,
    head.kind == KIND_STRING || head.kind == KIND_IDENT || head.kind == KIND_NUMBER,
    "Payload beat carries a kind other than string identifier or number.")
  `STT_ASSERT_IMPLY(a_dot_warning, clk, rst, m_tvalid && head.warn == WARN_DOT,
    head.pay && head.kind == KIND_NUMBER && head.data == 8'h2E,
    "Extra dot warning on a beat that is not a number dot.")
  `STT_ASSERT_NEXT(a_byte_held, clk, rst, s_tvalid && s_tready,
    byte_vld, "Accepted byte did not reach the input register.")

endmodule

/* dv/source_text_tokenizer_test.sv */
module source_text_tokenizer_test;
  import stt_pkg::*;

  typedef enum logic [3:0] {
    LX_IDLE, LX_OP, LX_LINE, LX_BLOCK, LX_STAR, LX_STR, LX_ESC, LX_IDENT, LX_NUM
  } lex_mode_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    kind_t       kind;
    logic        pay;
    logic [7:0]  data;
    logic [31:0] line;
    warn_t       warn;
  } row_t;

  localparam int OpeningRows = 27;
  localparam int RandomBytes = 353;
  localparam int SettleBytes = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;   // payload_byte, line_number, warning, zero fill
  logic [6:0]  m_tuser;   // token_kind, is_payload
  logic        m_tlast;

  lex_mode_t   lx_mode = LX_IDLE;
  logic [7:0]  held_op = 8'h00;
  logic [8:0]  kw_alive = '0;
  logic [3:0]  name_len = '0;
  logic        num_dot = 1'b0;
  logic [31:0] line_cnt = '0;
  logic [31:0] beat_line = '0;
  res_t        step_beats[$];
  res_t        due_beats[$];
  row_t        text_plan[$];
  res_t        got;
  res_t        want;
  int          flaw_cnt = 0;
  bit          settle = 1'b0;
  bit          burst_on = 1'b1;

  string kw_word [9] = '{
    "type", "if", "ifn", "int8", "else", "for", "while", "return", "namespace"
  };
  string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string op_chars = "=&|!+-*/<>";
  string punct_chars = ";,.:()[]{}^";
  string esc_codes = "nt\"\\vrf0";
  logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  row_t opening [OpeningRows] = '{
    '{";",   1'b1, KIND_SEMI,   1'b0, 8'h00, 32'd0, WARN_NONE},
    '{8'hFF, 1'b1, KIND_ERROR,  1'b0, 8'hFF, 32'd0, WARN_NONE},
    '{8'h0A, 1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{".",   1'b1, KIND_DOT,    1'b0, 8'h00, 32'd1, WARN_NONE},
    '{"\"",  1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{"\\",  1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{"q",   1'b1, KIND_STRING, 1'b1, "q",   32'd1, WARN_ESCAPE},
    '{"\\",  1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{"n",   1'b1, KIND_STRING, 1'b1, 8'h0A, 32'd1, WARN_NONE},
    '{"\"",  1'b1, KIND_STRING, 1'b0, 8'h00, 32'd1, WARN_NONE},
    '{"7",   1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{".",   1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{".",   1'b1, KIND_NUMBER, 1'b1, ".",   32'd1, WARN_DOT},
    '{" ",   1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{"i",   1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{"f",   1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{"=",   1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{"=",   1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{"/",   1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{"*",   1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{"*",   1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{8'h0A, 1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{8'h00, 1'b1, KIND_ERROR,  1'b0, 8'h00, 32'd2, WARN_OPEN},
    '{"\"",  1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{8'h00, 1'b1, KIND_STRING, 1'b0, 8'h00, 32'd0, WARN_OPEN},
    '{"/",   1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE},
    '{"/",   1'b0, KIND_ERROR,  1'b0, 8'h00, 32'd0, WARN_NONE}
  };

  source_text_tokenizer uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #6 clk = ~clk;

  function automatic bit is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic clear_all();
    lx_mode = LX_IDLE;
    held_op = 8'h00;
    kw_alive = '0;
    name_len = '0;
    num_dot = 1'b0;
    line_cnt = '0;
  endtask

  task automatic bump_line();
    if (line_cnt != '1) line_cnt++;
  endtask

  task automatic add_beat(input kind_t kind, input logic pay, input logic [7:0] data,
                          input warn_t warn);
    res_t r;
    r.kind = kind;
    r.pay = pay;
    r.data = data;
    r.line = beat_line;
    r.warn = warn;
    r.last = 1'b0;
    step_beats.push_back(r);
  endtask

  task automatic feed_name(input logic [7:0] b);
    string s;
    for (int k = 0; k < 9; k++) begin
      s = kw_word[k];
      if (!(name_len < s.len() && s[name_len] == b)) kw_alive[k] = 1'b0;
    end
    if (name_len < 15) name_len++;
  endtask

  function automatic kind_t name_kind();
    string s;
    for (int k = 0; k < 9; k++) begin
      s = kw_word[k];
      if (kw_alive[k] && name_len == s.len()) return kind_t'(KIND_KW_TYPE + k);
    end
    return KIND_IDENT;
  endfunction

  function automatic void op_pair(input logic [7:0] op, output kind_t one,
                                  output kind_t two, output logic [7:0] nxt);
    nxt = "=";
    case (op)
      "=": begin one = KIND_ASSIGN; two = KIND_EQ; end
      "&": begin one = KIND_AND; two = KIND_LAND; nxt = "&"; end
      "|": begin one = KIND_OR; two = KIND_LOR; nxt = "|"; end
      "!": begin one = KIND_NOT; two = KIND_NE; end
      "+": begin one = KIND_ADD; two = KIND_ADD_ASSIGN; end
      "-": begin one = KIND_SUB; two = KIND_SUB_ASSIGN; end
      "*": begin one = KIND_MUL; two = KIND_MUL_ASSIGN; end
      "/": begin one = KIND_DIV; two = KIND_DIV_ASSIGN; end
      "<": begin one = KIND_LT; two = KIND_LE; end
      default: begin one = KIND_GT; two = KIND_GE; end
    endcase
  endfunction

  task automatic take_idle(input logic [7:0] b);
    lx_mode = LX_IDLE;
    case (b)
      8'h00: clear_all();
      8'h0A: bump_line();
      8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D: ;
      ";": add_beat(KIND_SEMI, 1'b0, 8'h00, WARN_NONE);
      ",": add_beat(KIND_COMMA, 1'b0, 8'h00, WARN_NONE);
      ".": add_beat(KIND_DOT, 1'b0, 8'h00, WARN_NONE);
      ":": add_beat(KIND_COLON, 1'b0, 8'h00, WARN_NONE);
      "(": add_beat(KIND_LPAREN, 1'b0, 8'h00, WARN_NONE);
      ")": add_beat(KIND_RPAREN, 1'b0, 8'h00, WARN_NONE);
      "[": add_beat(KIND_LBRACK, 1'b0, 8'h00, WARN_NONE);
      "]": add_beat(KIND_RBRACK, 1'b0, 8'h00, WARN_NONE);
      "{": add_beat(KIND_LBRACE, 1'b0, 8'h00, WARN_NONE);
      "}": add_beat(KIND_RBRACE, 1'b0, 8'h00, WARN_NONE);
      "^": add_beat(KIND_XOR, 1'b0, 8'h00, WARN_NONE);
      "=", "&", "|", "!", "+", "-", "*", "/", "<", ">": begin
        lx_mode = LX_OP;
        held_op = b;
      end
      "\"": lx_mode = LX_STR;
      default: begin
        if (is_letter(b)) begin
          lx_mode = LX_IDENT;
          kw_alive = '1;
          name_len = '0;
          feed_name(b);
          add_beat(KIND_IDENT, 1'b1, b, WARN_NONE);
        end else if (is_digit(b)) begin
          lx_mode = LX_NUM;
          num_dot = 1'b0;
          add_beat(KIND_NUMBER, 1'b1, b, WARN_NONE);
        end else begin
          add_beat(KIND_ERROR, 1'b0, b, WARN_NONE);
        end
      end
    endcase
  endtask

  task automatic lex_byte(input logic [7:0] b);
    kind_t one, two;
    logic [7:0] nxt, v;
    bit ok;
    step_beats.delete();
    beat_line = line_cnt;
    case (lx_mode)
      LX_OP: begin
        op_pair(held_op, one, two, nxt);
        held_op = 8'h00;
        lx_mode = LX_IDLE;
        if (one == KIND_DIV && b == "/") begin
          lx_mode = LX_LINE;
        end else if (one == KIND_DIV && b == "*") begin
          lx_mode = LX_BLOCK;
        end else if (b == nxt) begin
          add_beat(two, 1'b0, 8'h00, WARN_NONE);
        end else begin
          add_beat(one, 1'b0, 8'h00, WARN_NONE);
          take_idle(b);
        end
      end
      LX_LINE: begin
        if (b == 8'h0A) begin
          bump_line();
          lx_mode = LX_IDLE;
        end else if (b == 8'h00) begin
          take_idle(b);
        end
      end
      LX_BLOCK, LX_STAR: begin
        if (b == 8'h00) begin
          add_beat(KIND_ERROR, 1'b0, 8'h00, WARN_OPEN);
          take_idle(b);
        end else if (lx_mode == LX_STAR && b == "/") begin
          lx_mode = LX_IDLE;
        end else begin
          if (b == 8'h0A) bump_line();
          lx_mode = (b == "*") ? LX_STAR : LX_BLOCK;
        end
      end
      LX_STR: begin
        if (b == 8'h00) begin
          add_beat(KIND_STRING, 1'b0, 8'h00, WARN_OPEN);
          take_idle(b);
        end else if (b == "\"") begin
          add_beat(KIND_STRING, 1'b0, 8'h00, WARN_NONE);
          lx_mode = LX_IDLE;
        end else if (b == "\\") begin
          lx_mode = LX_ESC;
        end else begin
          if (b == 8'h0A) bump_line();
          add_beat(KIND_STRING, 1'b1, b, WARN_NONE);
        end
      end
      LX_ESC: begin
        if (b == 8'h00) begin
          add_beat(KIND_STRING, 1'b0, 8'h00, WARN_OPEN);
          take_idle(b);
        end else begin
          if (b == 8'h0A) bump_line();
          ok = 1'b1;
          case (b)
            "n": v = 8'h0A;
            "t": v = 8'h09;
            "\"", "\\": v = b;
            "v": v = 8'h0B;
            "r": v = 8'h0D;
            "f": v = 8'h0C;
            "0": v = 8'h00;
            default: begin v = b; ok = 1'b0; end
          endcase
          add_beat(KIND_STRING, 1'b1, v, ok ? WARN_NONE : WARN_ESCAPE);
          lx_mode = LX_STR;
        end
      end
      LX_IDENT: begin
        if (is_letter(b) || is_digit(b)) begin
          feed_name(b);
          add_beat(KIND_IDENT, 1'b1, b, WARN_NONE);
        end else begin
          add_beat(name_kind(), 1'b0, 8'h00, WARN_NONE);
          kw_alive = '0;
          name_len = '0;
          take_idle(b);
        end
      end
      LX_NUM: begin
        if (is_digit(b)) begin
          add_beat(KIND_NUMBER, 1'b1, b, WARN_NONE);
        end else if (b == ".") begin
          add_beat(KIND_NUMBER, 1'b1, ".", num_dot ? WARN_DOT : WARN_NONE);
          num_dot = 1'b1;
        end else begin
          add_beat(KIND_NUMBER, 1'b0, 8'h00, WARN_NONE);
          num_dot = 1'b0;
          take_idle(b);
        end
      end
      default: take_idle(b);
    endcase
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
  endtask

  task automatic put(input logic [7:0] b);
    row_t r;
    r = '0;
    r.b = b;
    text_plan.push_back(r);
  endtask

  task automatic add_token();
    int cat, n, k;
    string w;
    logic [7:0] c;
    cat = $urandom_range(0, 14);
    case (cat)
      0, 1: begin
        w = kw_word[$urandom_range(0, 8)];
        n = w.len();
        k = $urandom_range(0, 3);
        if (k == 0) n = $urandom_range(1, n);
        for (int i = 0; i < n; i++) put(w[i]);
        if (k == 1) put(alnum[$urandom_range(0, 62)]);
      end
      2, 3: begin
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 4);
        put(alnum[$urandom_range(0, 52)]);
        for (int i = 1; i < n; i++) put(alnum[$urandom_range(0, 62)]);
      end
      4, 5: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) put(8'(8'h30 + $urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 1) begin
          put(".");
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) put(8'(8'h30 + $urandom_range(0, 9)));
          if ($urandom_range(0, 2) == 0) begin
            put(".");
            put(8'(8'h30 + $urandom_range(0, 9)));
          end
        end
      end
      6: begin
        put("\"");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          k = $urandom_range(0, 5);
          if (k == 0) begin
            put("\\");
            put(esc_codes[$urandom_range(0, 7)]);
          end else if (k == 1) begin
            put("\\");
            put(8'($urandom_range(1, 255)));
          end else if (k == 2) begin
            put(8'h0A);
          end else begin
            c = 8'($urandom_range(32, 126));
            put((c == "\"" || c == "\\") ? 8'h61 : c);
          end
        end
        k = $urandom_range(0, 9);
        if (k == 0) begin
          put(8'h00);
        end else if (k == 1) begin
          put("\\");
          put(8'h00);
        end else begin
          put("\"");
        end
      end
      7, 8: begin
        c = op_chars[$urandom_range(0, 9)];
        put(c);
        k = $urandom_range(0, 3);
        if (k == 0) put("=");
        else if (k == 1 && c != "/") put(c);
      end
      9: put(punct_chars[$urandom_range(0, 10)]);
      10: put(blanks[$urandom_range(0, 5)]);
      11: begin
        put("/");
        put("/");
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) put(8'($urandom_range(32, 126)));
        put(($urandom_range(0, 5) == 0) ? 8'h00 : 8'h0A);
      end
      12: begin
        put("/");
        put("*");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
          k = $urandom_range(0, 3);
          put((k == 0) ? 8'h2A : (k == 1) ? 8'h0A : 8'(8'h61 + $urandom_range(0, 25)));
        end
        if ($urandom_range(0, 7) == 0) begin
          put(8'h00);
        end else begin
          put("*");
          put("/");
        end
      end
      13: put(8'($urandom_range(0, 255)));
      default: begin
        if ($urandom_range(0, 2) == 0) put(8'h00);
        else put(8'(8'h80 + $urandom_range(0, 127)));
      end
    endcase
    k = $urandom_range(0, 5);
    if (k < 2) put(" ");
    else if (k == 2) put(8'h0A);
  endtask

  initial begin
    res_t r;
    clear_all();
    foreach (opening[i]) text_plan.push_back(opening[i]);
    while (text_plan.size() < OpeningRows + RandomBytes) add_token();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < text_plan.size(); i++) begin
      if (i == OpeningRows) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_beats.size() != 0) @(posedge clk);
      end else if (!settle && burst_on && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      if ($urandom_range(0, 15) == 0) burst_on = !burst_on;
      if (i >= text_plan.size() - SettleBytes) settle = 1'b1;
      s_tvalid <= 1'b1;
      s_tdata <= text_plan[i].b;
      do @(posedge clk); while (!s_tready);
      lex_byte(text_plan[i].b);
      if (text_plan[i].typed) begin
        r.kind = text_plan[i].kind;
        r.pay = text_plan[i].pay;
        r.data = text_plan[i].data;
        r.line = text_plan[i].line;
        r.warn = text_plan[i].warn;
        r.last = 1'b1;
        due_beats.push_back(r);
      end else begin
        foreach (step_beats[j]) due_beats.push_back(step_beats[j]);
      end
    end
    s_tvalid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (flaw_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    @(negedge rst);
    forever begin
      if (!settle && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat (settle ? 1 : $urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.kind = kind_t'(m_tuser[5:0]);
      got.pay = m_tuser[6];
      got.data = m_tdata[7:0];
      got.line = m_tdata[39:8];
      got.warn = warn_t'(m_tdata[41:40]);
      got.last = m_tlast;
      if (due_beats.size() == 0) begin
        if (flaw_cnt < 10)
          $display("%0t: unexpected beat kind %0d pay %0d data %h line %0d warn %0d last %0d",
                   $time, got.kind, got.pay, got.data, got.line, got.warn, got.last);
        flaw_cnt++;
      end else begin
        want = due_beats.pop_front();
        if (got.kind !== want.kind || got.pay !== want.pay || got.data !== want.data ||
            got.line !== want.line || got.warn !== want.warn || got.last !== want.last) begin
          if (flaw_cnt < 10) begin
            $write("%0t: mismatch (expected/actual) kind %0d/%0d pay %0d/%0d data %h/%h",
                   $time, want.kind, got.kind, want.pay, got.pay, want.data, got.data);
            $display(" line %0d/%0d warn %0d/%0d last %0d/%0d",
                     want.line, got.line, want.warn, got.warn, want.last, got.last);
          end
          flaw_cnt++;
        end
      end
    end
  end

  initial begin
    #2400000;
    $display("FAILURE");
    $finish;
  end

endmodule
